// ----- hdl/ppf_pkg.sv -----
package ppf_pkg;

  localparam int GEO_W = 24;
  localparam int OUT_W = 48;
  localparam int ORD_W = 4;

  localparam logic [1:0] KIND_CUT = 2'd0;
  localparam logic [1:0] KIND_NOCUT = 2'd1;
  localparam logic [1:0] KIND_POT = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_CUT = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic [1:0] REG_GROUND = 2'd0;
  localparam logic [1:0] REG_DEPTH = 2'd1;
  localparam logic [1:0] REG_ORDER = 2'd2;
  localparam logic [1:0] REG_CUTOFF = 2'd3;

  localparam logic [47:0] POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] NEG_MAX = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic       zero;
    logic       cut;
    logic       pot;
    logic       huge;
    logic [3:0] n;
  } flags_t;

endpackage

// ----- hdl/ppf_div.sv -----
module ppf_div #(
  parameter int NW = 56,
  parameter int DW = 24,
  parameter int SW = 1,
  parameter int AW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [NW-1:0] q_r [NW+1];
  logic [DW:0]   r_r [NW+1];
  logic [DW-1:0] d_r [NW+1];
  logic [SW-1:0] s_r [NW+1];
  logic          v_r [NW+1];

  always_comb begin
    q_r[0] = num;
    r_r[0] = '0;
    d_r[0] = den;
    s_r[0] = side_in;
    v_r[0] = in_valid;
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic [NW-1:0] qs;
    logic [DW:0] rs;
    logic [DW:0] r_q;
    logic [NW-1:0] q_q;
    logic [DW-1:0] d_q;
    logic [SW-1:0] s_q;
    logic v_q;
    always_comb begin
      trial = {r_r[i][DW-1:0], q_r[i][NW-1]};
      diff = trial - {1'b0, d_r[i]};
      if (trial >= {1'b0, d_r[i]}) begin
        rs = diff;
        qs = {q_r[i][NW-2:0], 1'b1};
      end else begin
        rs = trial;
        qs = {q_r[i][NW-2:0], 1'b0};
      end
    end
    if ((i % AW) == AW - 1) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          v_q <= 1'b0;
        end else if (en) begin
          v_q <= v_r[i];
        end
        if (en) begin
          r_q <= rs;
          q_q <= qs;
          d_q <= d_r[i];
          s_q <= s_r[i];
        end
      end
    end else begin : g_cmb
      always_comb begin
        v_q = v_r[i];
        r_q = rs;
        q_q = qs;
        d_q = d_r[i];
        s_q = s_r[i];
      end
    end
    always_comb begin
      v_r[i+1] = v_q;
      r_r[i+1] = r_q;
      q_r[i+1] = q_q;
      d_r[i+1] = d_q;
      s_r[i+1] = s_q;
    end
  end

  assign out_valid = v_r[NW];
  assign quo = q_r[NW];
  assign side_out = s_r[NW];

endmodule

// two-stage multiplier: partial products of the 32-bit operand halves, then their sum
module ppf_mul #(
  parameter int AW = 57,
  parameter int BW = 57,
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output logic [AW+BW-1:0] prod,
  output logic [SW-1:0]    side_out
);

  localparam int PW = AW + BW;

  logic [63:0]   p00;
  logic [BW-1:0] p01;
  logic [AW-1:0] p10;
  logic [PW-65:0] p11;
  logic          v1;
  logic [SW-1:0] s1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      p00 <= 64'(a[31:0]) * 64'(b[31:0]);
      p01 <= BW'(a[31:0]) * BW'(b[BW-1:32]);
      p10 <= AW'(a[AW-1:32]) * AW'(b[31:0]);
      p11 <= (PW-64)'(a[AW-1:32]) * (PW-64)'(b[BW-1:32]);
      s1 <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v1;
    if (en) begin
      prod <= PW'(p00) + PW'({p01, 32'd0}) + PW'({p10, 32'd0}) + {p11, 64'd0};
      side_out <= s1;
    end
  end

endmodule

// ----- hdl/pair_potential_force.sv -----
// Channel | Signals                              | Direction
// request | in_valid in_ready distance kind     | in
// result  | out_valid out_ready value status     | out
// config  | cfg_we cfg_index cfg_data            | in
// One request per cycle unless a held result stalls the pipeline. Every order passes through
// 28 stages in the ratio divider (two quotient bits each), two per order step (12 steps),
// two for the square, one for the subtract, two for the depth multiply, 26 in the force
// divider (four quotient bits each) and the output register.
// The whole pipeline advances only when its last stage is empty or taken,
// so a stall holds every stage in place. Reset clears the valid bits and
// loads the register reset values.
module pair_potential_force #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_ORDER = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] distance,
  input  logic [1:0]  kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] value,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PSH = FRAC_BITS + 16 - 24;

  logic [23:0] ground_position, well_depth, cutoff_distance;
  logic [3:0]  power_order;
  logic        en;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_position <= 24'(1 << FRAC_BITS);
      well_depth <= 24'(1 << FRAC_BITS);
      power_order <= 4'd6;
      cutoff_distance <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        ppf_pkg::REG_GROUND: ground_position <= cfg_data;
        ppf_pkg::REG_DEPTH: well_depth <= cfg_data;
        ppf_pkg::REG_ORDER: power_order <= cfg_data[3:0];
        ppf_pkg::REG_CUTOFF: cutoff_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: decode and ratio division
  ppf_pkg::flags_t fa;
  logic [3:0] n_clamp;
  always_comb begin
    n_clamp = (32'(power_order) > 32'(MAX_ORDER)) ? 4'(MAX_ORDER) : power_order;
    fa.zero = (distance == '0);
    fa.cut = (kind == ppf_pkg::KIND_CUT) && (distance > cutoff_distance);
    fa.pot = kind[1];
    fa.huge = 1'b0;
    fa.n = n_clamp;
  end

  localparam int SA = 8 + 24;
  logic        dv_v;
  logic [55:0] r_q;
  logic [SA-1:0] sa_out;
  ppf_div #(.NW(56), .DW(24), .SW(SA), .AW(2)) u_rdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid && in_ready),
    .num({ground_position, 32'd0}),
    .den(distance == '0 ? 24'd1 : distance),
    .side_in({fa, distance}), .out_valid(dv_v), .quo(r_q), .side_out(sa_out));

  // power chain: one two-stage multiply per order step
  localparam int PSW = 57 + 56 + 8 + 24;
  logic          pv [MAX_ORDER+1];
  logic [56:0]   pt [MAX_ORDER+1];
  logic [55:0]   pr [MAX_ORDER+1];
  ppf_pkg::flags_t pf [MAX_ORDER+1];
  logic [23:0]   px [MAX_ORDER+1];

  always_comb begin
    pv[0] = dv_v;
    pt[0] = 57'(64'd1 << 32);
    pr[0] = r_q;
    pf[0] = sa_out[SA-1:24];
    px[0] = sa_out[23:0];
  end

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_pow
    logic          cv;
    logic [113:0]  prod;
    logic [PSW-1:0] cs;
    logic [56:0]   t_in;
    logic [55:0]   r_in;
    ppf_pkg::flags_t f_in;
    logic [23:0]   x_in;
    logic [81:0]   q;
    logic [56:0]   tn;
    ppf_pkg::flags_t fn;
    ppf_mul #(.AW(57), .BW(57), .SW(PSW)) u_mul (
      .clk(clk), .rst(rst), .en(en), .in_valid(pv[k]), .a(pt[k]), .b({1'b0, pr[k]}),
      .side_in({pt[k], pr[k], pf[k], px[k]}), .out_valid(cv), .prod(prod),
      .side_out(cs));
    always_comb begin
      {t_in, r_in, f_in, x_in} = cs;
      q = prod[113:32];
      fn = f_in;
      tn = t_in;
      if (!f_in.huge && (k < int'(f_in.n))) begin
        if (q >= 82'(64'd1 << 56)) fn.huge = 1'b1;
        else tn = q[56:0];
      end
      pv[k+1] = cv;
      pt[k+1] = tn;
      pr[k+1] = r_in;
      pf[k+1] = fn;
      px[k+1] = x_in;
    end
  end

  // stage S: square and subtract
  localparam int QSW = 57 + 8 + 24;
  logic        qv;
  logic [QSW-1:0] qs;
  logic [56:0] qt;
  ppf_pkg::flags_t qf;
  logic [23:0] qx;
  logic        sv;
  logic [63:0] smag;
  logic        sneg;
  ppf_pkg::flags_t sf;
  logic [23:0] sx;
  logic [113:0] sq;
  logic [65:0]  t2, sub;

  ppf_mul #(.AW(57), .BW(57), .SW(QSW)) u_sq (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv[MAX_ORDER]),
    .a(pt[MAX_ORDER]), .b(pt[MAX_ORDER]),
    .side_in({pt[MAX_ORDER], pf[MAX_ORDER], px[MAX_ORDER]}),
    .out_valid(qv), .prod(sq), .side_out(qs));

  always_comb begin
    {qt, qf, qx} = qs;
    t2 = 66'(sq[113:48]);
    sub = qf.pot ? 66'({qt[56:16], 1'b0}) : 66'(qt[56:16]);
  end
  always_ff @(posedge clk) begin
    if (rst) sv <= 1'b0;
    else if (en) sv <= qv;
    if (en) begin
      sneg <= t2 < sub;
      smag <= 64'((t2 < sub) ? sub - t2 : t2 - sub);
      sf <= qf;
      sx <= qx;
    end
  end

  // stage M: scale by depth
  localparam int MSW = 1 + 8 + 24;
  logic        mv;
  logic [103:0] mprod;
  logic        mneg;
  ppf_pkg::flags_t mf;
  logic [23:0] mx;
  logic [39:0] coef;
  logic [MSW-1:0] ms_out;
  always_comb begin
    coef = sf.pot ? 40'(well_depth) : 40'({35'd0, sf.n} * well_depth * 2) << 8;
  end
  ppf_mul #(.AW(40), .BW(64), .SW(MSW)) u_dmul (
    .clk(clk), .rst(rst), .en(en), .in_valid(sv), .a(coef), .b(smag),
    .side_in({sneg, sf, sx}), .out_valid(mv), .prod(mprod), .side_out(ms_out));
  always_comb begin
    {mneg, mf, mx} = ms_out;
  end

  // stage D: force division
  logic [103:0] num2;
  assign num2 = mf.pot ? (mprod >> PSH) : mprod;
  localparam int SB = 8 + 1;
  logic        dv2;
  logic [103:0] p;
  logic [SB-1:0] sb_out;
  ppf_div #(.NW(104), .DW(24), .SW(SB), .AW(4)) u_fdiv (
    .clk(clk), .rst(rst), .en(en), .in_valid(mv),
    .num(num2), .den((mf.pot || mx == '0) ? 24'd1 : mx),
    .side_in({mf, mneg}), .out_valid(dv2), .quo(p), .side_out(sb_out));

  ppf_pkg::flags_t of;
  logic oneg;
  logic [47:0] v_n;
  logic [1:0]  s_n;
  always_comb begin
    of = sb_out[SB-1:1];
    oneg = sb_out[0];
    v_n = '0;
    s_n = ppf_pkg::ST_OK;
    if (of.zero) s_n = ppf_pkg::ST_ZERO;
    else if (of.cut) s_n = ppf_pkg::ST_CUT;
    else if (of.huge) begin
      if (well_depth != '0) begin
        v_n = ppf_pkg::POS_MAX;
        s_n = ppf_pkg::ST_SAT;
      end
    end else if (p > (oneg ? 104'(ppf_pkg::NEG_MAX) : 104'(ppf_pkg::POS_MAX))) begin
      v_n = oneg ? ppf_pkg::NEG_MAX : ppf_pkg::POS_MAX;
      s_n = ppf_pkg::ST_SAT;
    end else begin
      v_n = oneg ? 48'(-p[47:0]) : p[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv2;
    if (en) begin
      value <= v_n;
      status <= s_n;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ppf_pkg::ST_ZERO |-> value == '0)
    else $error("zero distance gave nonzero value");
  a_cut: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ppf_pkg::ST_CUT |-> value == '0)
    else $error("cutoff gave nonzero value");

endmodule
